// File: hw/rtl/dass_pkg.sv
// ----------------------------------------------------------------------------
// dass_pkg
// shared widths, types and helper functions of the allele sampler
// ----------------------------------------------------------------------------
package dass_pkg;

    localparam int MAX_INDIVIDUALS_DEF = 64;
    localparam int CFG_W               = 7;
    localparam int COUNT_W             = 8;
    localparam int DRAW_W              = 16;
    localparam int TOTAL_W             = 10;
    localparam int INDEX_W             = 6;
    localparam int S_TDATA_W           = 48;
    localparam int M_TDATA_W           = 8;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd2;
    localparam logic [CFG_W-1:0] MIN_N     = 7'd2;

    typedef logic [1:0] allele_t;

    // one accepted site waiting for readout
    typedef struct packed {
        logic             bank;
        allele_t          first;
        logic [CFG_W-1:0] count;
    } job_t;

    // readout status back to the front
    typedef struct packed {
        logic done;
        logic bank;
    } back_status_t;

    function automatic logic [2:0] count4(input logic [3:0] m);
        return {2'b00, m[0]} + {2'b00, m[1]} + {2'b00, m[2]} + {2'b00, m[3]};
    endfunction

    // lowest set allele, 3 when none of the lower three are set
    function automatic allele_t lowest_allele(input logic [3:0] m);
        allele_t a;
        a = 2'd3;
        if (m[2]) a = 2'd2;
        if (m[1]) a = 2'd1;
        if (m[0]) a = 2'd0;
        return a;
    endfunction

endpackage

// File: hw/rtl/dass_ram.sv
// ----------------------------------------------------------------------------
// dass_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module dass_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/dass_front.sv
// ----------------------------------------------------------------------------
// dass_front
// takes one word per individual, draws its allele, stores it, and at the
// end of a site decides whether the site is emitted
// ----------------------------------------------------------------------------
module dass_front
    import dass_pkg::*;
#(
    parameter int MAX_INDIVIDUALS = MAX_INDIVIDUALS_DEF,
    parameter int IDX_W           = $clog2(MAX_INDIVIDUALS)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 ram_wr_en,
    output logic [IDX_W:0]       ram_wr_addr,
    output allele_t              ram_wr_data,
    output logic                 job_push,
    output job_t                 job,
    input  back_status_t         back_status
);

    localparam logic [CFG_W-1:0] MAX_N = CFG_W'(MAX_INDIVIDUALS);

    logic [CFG_W-1:0] cfg_reg;
    logic [CFG_W-1:0] cnt_reg,  cnt_next;
    logic [3:0]       obs_reg,  obs_next;
    logic [3:0]       smp_reg,  smp_next;
    logic             depth_reg, depth_next;
    logic             bank_reg, bank_next;
    logic [1:0]       busy_reg, busy_next;

    logic [COUNT_W-1:0]        cnt_a, cnt_c, cnt_g, cnt_t;
    logic [DRAW_W-1:0]         draw;
    logic [TOTAL_W-1:0]        cum0, cum1, cum2, total;
    logic [DRAW_W+TOTAL_W-1:0] scaled;
    logic [TOTAL_W-1:0]        q;
    allele_t                   allele;
    logic [3:0]                nz;
    logic [CFG_W-1:0]          n_eff, cnt_inc;
    logic                      accept, site_end, site_ok;

    assign cnt_a = s_tdata[7:0];
    assign cnt_c = s_tdata[15:8];
    assign cnt_g = s_tdata[23:16];
    assign cnt_t = s_tdata[31:24];
    assign draw  = s_tdata[47:32];

    assign cum0  = TOTAL_W'(cnt_a);
    assign cum1  = cum0 + TOTAL_W'(cnt_c);
    assign cum2  = cum1 + TOTAL_W'(cnt_g);
    assign total = cum2 + TOTAL_W'(cnt_t);

    // r*total < cum<<16 is the same as (r*total)>>16 < cum
    assign scaled = (DRAW_W+TOTAL_W)'(draw) * (DRAW_W+TOTAL_W)'(total);
    assign q      = scaled[DRAW_W+TOTAL_W-1:DRAW_W];

    always_comb begin
        if (total == '0)   allele = 2'd0;
        else if (q < cum0) allele = 2'd0;
        else if (q < cum1) allele = 2'd1;
        else if (q < cum2) allele = 2'd2;
        else               allele = 2'd3;
    end

    assign nz = {cnt_t != '0, cnt_g != '0, cnt_c != '0, cnt_a != '0};

    always_comb begin
        if (cfg_reg < MIN_N)      n_eff = MIN_N;
        else if (cfg_reg > MAX_N) n_eff = MAX_N;
        else                      n_eff = cfg_reg;
    end

    assign s_tready  = !busy_reg[bank_reg];
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    assign cnt_inc  = cnt_reg + 1'b1;
    assign obs_next = obs_reg | nz;
    assign smp_next = smp_reg | (4'b0001 << allele);
    assign depth_next = depth_reg && (total != '0);
    assign site_end = accept && (cnt_inc >= n_eff);
    assign site_ok  = depth_next && (count4(obs_next) == 3'd2)
                      && (count4(smp_next) == 3'd2);

    assign ram_wr_en   = accept;
    assign ram_wr_addr = {bank_reg, cnt_reg[IDX_W-1:0]};
    assign ram_wr_data = allele;

    assign job_push  = site_end && site_ok;
    assign job.bank  = bank_reg;
    assign job.first = lowest_allele(smp_next);
    assign job.count = n_eff;

    always_comb begin
        busy_next = busy_reg;
        if (back_status.done) busy_next[back_status.bank] = 1'b0;
        if (job_push)         busy_next[bank_reg] = 1'b1;
    end

    assign bank_next = job_push ? !bank_reg : bank_reg;
    assign cnt_next  = site_end ? '0 : cnt_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg   <= CFG_RESET;
            cnt_reg   <= '0;
            obs_reg   <= '0;
            smp_reg   <= '0;
            depth_reg <= 1'b1;
            bank_reg  <= 1'b0;
            busy_reg  <= '0;
        end else begin
            if (cfg_valid && cfg_ready) cfg_reg <= cfg_data;
            busy_reg <= busy_next;
            bank_reg <= bank_next;
            if (accept) begin
                cnt_reg   <= cnt_next;
                obs_reg   <= site_end ? 4'b0000 : obs_next;
                smp_reg   <= site_end ? 4'b0000 : smp_next;
                depth_reg <= site_end ? 1'b1 : depth_next;
            end
        end
    end

endmodule

// File: hw/rtl/dass_job_fifo.sv
// ----------------------------------------------------------------------------
// dass_job_fifo
// two entry queue of accepted sites between front and readout
// ----------------------------------------------------------------------------
module dass_job_fifo
    import dass_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head_job,
    output logic empty,
    output logic full
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    assign empty    = (fill_reg == 2'd0);
    assign full     = (fill_reg == 2'd2);
    assign head_job = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push && !full)  wr_ptr_reg <= !wr_ptr_reg;
            if (pop && !empty)  rd_ptr_reg <= !rd_ptr_reg;
            fill_reg <= fill_reg + {1'b0, push && !full} - {1'b0, pop && !empty};
        end
    end

endmodule

// File: hw/rtl/dass_back.sv
// ----------------------------------------------------------------------------
// dass_back
// reads the stored alleles of a queued site and emits one word per individual
// ----------------------------------------------------------------------------
module dass_back
    import dass_pkg::*;
#(
    parameter int IDX_W = $clog2(MAX_INDIVIDUALS_DEF)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  job_t                 head_job,
    input  logic                 empty,
    output logic                 pop,
    output logic                 ram_rd_en,
    output logic [IDX_W:0]       ram_rd_addr,
    input  allele_t              ram_rd_data,
    output back_status_t         status,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    typedef enum logic {
        ST_READ,
        ST_LOAD
    } state_t;

    state_t           state_reg, state_next;
    logic [CFG_W-1:0] k_reg, k_next;
    logic             m_valid_reg, m_valid_next;
    logic [INDEX_W-1:0] idx_reg;
    logic             first_reg, last_reg;
    logic             load, is_last;

    assign is_last = (k_reg + 1'b1) == head_job.count;
    assign load    = (state_reg == ST_LOAD) && (!m_valid_reg || m_tready);

    assign ram_rd_en   = (state_reg == ST_READ) && !empty;
    assign ram_rd_addr = {head_job.bank, k_reg[IDX_W-1:0]};

    assign pop         = load && is_last;
    assign status.done = pop;
    assign status.bank = head_job.bank;

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_READ: begin
                if (!empty) state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    k_next       = is_last ? '0 : k_reg + 1'b1;
                    state_next   = ST_READ;
                end
            end
            default: state_next = ST_READ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_READ;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
        if (load) begin
            idx_reg   <= k_reg[INDEX_W-1:0];
            first_reg <= (ram_rd_data == head_job.first);
            last_reg  <= is_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, first_reg, idx_reg};
    assign m_tlast  = last_reg;

endmodule

// File: hw/rtl/diallelic_site_allele_sampler.sv
// ----------------------------------------------------------------------------
// diallelic_site_allele_sampler
// per site allele draw and diallelic genotype output
// ----------------------------------------------------------------------------
// usage:
//   s_ channel takes one word per individual: four base counts and a 16-bit
//   random fraction. one word is taken per cycle while s_tready is high.
//   after the num_individuals-th word the site is checked (all depths
//   nonzero, two bases seen, two alleles drawn). a passing site queues for
//   readout; a failing one produces no words.
//   m_ channel gives one word per individual, index 0 first, tlast on the
//   final one. readout of each word is the registered read of the allele
//   ram followed by the output register load.
//   a site's first word passes the job queue, ram read and output register.
//   the allele ram has two banks, so the next site loads while the previous
//   one is read out; s_tready drops only if both banks hold pending sites.
//   a stalled m_ receiver holds its word and, once both banks are pending,
//   backs up into s_tready.
//   cfg_data sets num_individuals (clamped to 2..MAX_INDIVIDUALS); reset
//   value 2. reset (aresetn low) empties the queue and starts a new site.
// ----------------------------------------------------------------------------
module diallelic_site_allele_sampler
    import dass_pkg::*;
#(
    parameter int MAX_INDIVIDUALS = MAX_INDIVIDUALS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // count_a, count_c, count_g, count_t, random_draw
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // individual_index, is_first_allele, zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int IDX_W = $clog2(MAX_INDIVIDUALS);
    localparam int RAM_DEPTH = 2 << IDX_W;

    logic         ram_wr_en, ram_rd_en;
    logic [IDX_W:0] ram_wr_addr, ram_rd_addr;
    allele_t      ram_wr_data, ram_rd_data;
    logic         job_push, pop, empty, full;
    job_t         job, head_job;
    back_status_t back_status;

    dass_front #(
        .MAX_INDIVIDUALS(MAX_INDIVIDUALS),
        .IDX_W(IDX_W)
    ) u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .ram_wr_en(ram_wr_en),
        .ram_wr_addr(ram_wr_addr),
        .ram_wr_data(ram_wr_data),
        .job_push(job_push),
        .job(job),
        .back_status(back_status)
    );

    dass_ram #(
        .WIDTH(2),
        .DEPTH(RAM_DEPTH)
    ) u_ram (
        .aclk(aclk),
        .wr_en(ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en(ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    dass_job_fifo u_fifo (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(job_push),
        .push_job(job),
        .pop(pop),
        .head_job(head_job),
        .empty(empty),
        .full(full)
    );

    dass_back #(
        .IDX_W(IDX_W)
    ) u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .head_job(head_job),
        .empty(empty),
        .pop(pop),
        .ram_rd_en(ram_rd_en),
        .ram_rd_addr(ram_rd_addr),
        .ram_rd_data(ram_rd_data),
        .status(back_status),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    // a site can only be queued while its bank was free, so this never fires
    always_ff @(posedge aclk) begin
        if (aresetn && job_push && full) begin
            $error("site queued while queue full");
        end
    end

endmodule

// File: hw/rtl/dass_checker.sv
// ----------------------------------------------------------------------------
// dass_checker
// port level checks of the allele sampler, bound to the top level
// ----------------------------------------------------------------------------
module dass_checker
    import dass_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tlast
);

    // index expected on the next result word
    logic [INDEX_W-1:0] exp_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_idx_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            exp_idx_reg <= m_tlast ? '0 : m_tdata[INDEX_W-1:0] + 1'b1;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_index_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[INDEX_W-1:0] == exp_idx_reg)
        else $error("result index out of order");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[M_TDATA_W-1])
        else $error("pad bit of result word set");

endmodule

bind diallelic_site_allele_sampler dass_checker u_checker (.*);

// File: tb/diallelic_site_allele_sampler_tb.sv
// ----------------------------------------------------------------------------
// diallelic_site_allele_sampler_tb
// self-checking bench for the per-site allele sampler
// ----------------------------------------------------------------------------
// individual words are queued per site and a clocked driver feeds them into
// the s_ channel. A predictor tracks the site tally and the allele draw of
// every accepted word, and it queues the genotype words that a passing site
// should give. A clocked monitor on the m_ channel checks each word against
// the oldest queued genotype. The run goes through a short directed set and
// then randomized sites at several site sizes, including the clamped ends
// and a size change in the middle of a site. Both sides idle at random, and
// one long receiver hold backs the block up into its input.
// ----------------------------------------------------------------------------
module diallelic_site_allele_sampler_tb;
    import dass_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 12;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int HOLD_CYCLES    = 300;
    localparam int TIMEOUT_CYCLES = 400000;

    localparam int BASE_A = 0;
    localparam int BASE_C = 1;
    localparam int BASE_G = 2;
    localparam int BASE_T = 3;

    // s_tdata layout, lowest bits last in the list
    typedef struct packed {
        logic [DRAW_W-1:0]  random_draw;
        logic [COUNT_W-1:0] count_t;
        logic [COUNT_W-1:0] count_g;
        logic [COUNT_W-1:0] count_c;
        logic [COUNT_W-1:0] count_a;
    } base_word_t;

    typedef struct packed {
        logic [INDEX_W-1:0] individual_index;
        logic               is_first_allele;
        logic               last;
    } genotype_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data  = '0;

    base_word_t words_to_send[$];
    genotype_t  genotypes_due[$];
    base_word_t word_on_bus;
    int         mismatch_count = 0;
    int         gap_left;
    int         stall_left;
    bit         src_gaps_on  = 1'b0;
    bit         sink_gaps_on = 1'b0;
    bit         hold_go      = 1'b0;
    logic       hold_on      = 1'b0;

    // predictor state
    logic [CFG_W-1:0] site_size_reg = CFG_RESET;
    allele_t          site_allele[MAX_INDIVIDUALS_DEF];
    logic [3:0]       seen_bases     = 4'b0000;
    logic [3:0]       drawn_alleles  = 4'b0000;
    logic             depth_ok       = 1'b1;
    int               loaded         = 0;

    diallelic_site_allele_sampler u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic int site_size(input logic [CFG_W-1:0] v);
        if (v < MIN_N) return int'(MIN_N);
        if (v > MAX_INDIVIDUALS_DEF) return MAX_INDIVIDUALS_DEF;
        return int'(v);
    endfunction

    // proportional draw: first base whose running count bound exceeds r*total
    function automatic allele_t sample_base(input base_word_t w);
        int unsigned cnt[4];
        int unsigned total;
        int unsigned scaled;
        int unsigned cum;
        cnt[BASE_A] = w.count_a;
        cnt[BASE_C] = w.count_c;
        cnt[BASE_G] = w.count_g;
        cnt[BASE_T] = w.count_t;
        total = cnt[0] + cnt[1] + cnt[2] + cnt[3];
        if (total == 0) return allele_t'(BASE_A);
        scaled = w.random_draw * total;
        cum = 0;
        for (int b = 0; b < 4; b++) begin
            cum += cnt[b];
            if (scaled < (cum << 16)) return allele_t'(b);
        end
        return allele_t'(BASE_T);
    endfunction

    function automatic void load_individual(input base_word_t w);
        allele_t   a;
        allele_t   low;
        int        n;
        genotype_t g;
        if (w.count_a != 0) seen_bases[BASE_A] = 1'b1;
        if (w.count_c != 0) seen_bases[BASE_C] = 1'b1;
        if (w.count_g != 0) seen_bases[BASE_G] = 1'b1;
        if (w.count_t != 0) seen_bases[BASE_T] = 1'b1;
        if (w.count_a == 0 && w.count_c == 0 && w.count_g == 0 && w.count_t == 0)
            depth_ok = 1'b0;
        a = sample_base(w);
        site_allele[loaded % MAX_INDIVIDUALS_DEF] = a;
        drawn_alleles[a] = 1'b1;
        loaded++;
        n = site_size(site_size_reg);
        if (loaded < n) return;
        if (depth_ok && $countones(seen_bases) == 2 && $countones(drawn_alleles) == 2) begin
            low = allele_t'(BASE_T);
            for (int b = 3; b >= 0; b--) begin
                if (drawn_alleles[b]) low = allele_t'(b);
            end
            for (int k = 0; k < n; k++) begin
                g.individual_index = INDEX_W'(k);
                g.is_first_allele  = (site_allele[k] == low);
                g.last             = (k == n - 1);
                genotypes_due.push_back(g);
            end
        end
        seen_bases    = 4'b0000;
        drawn_alleles = 4'b0000;
        depth_ok      = 1'b1;
        loaded        = 0;
    endfunction

    function automatic int idle_len();
        int pct;
        pct = $urandom_range(0, 99);
        if (pct < 55) return 0;
        if (pct < 85) return $urandom_range(1, 3);
        if (pct < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic base_word_t mk_word(input logic [7:0] a, input logic [7:0] c,
                                           input logic [7:0] g, input logic [7:0] t,
                                           input logic [15:0] r);
        base_word_t w;
        w.count_a     = a;
        w.count_c     = c;
        w.count_g     = g;
        w.count_t     = t;
        w.random_draw = r;
        return w;
    endfunction

    function automatic logic [7:0] pick_count();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(1, 3));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_draw();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // counts only on the two site bases, never an empty word
    function automatic base_word_t two_base_word(input int b1, input int b2);
        logic [7:0] cnt[4];
        for (int b = 0; b < 4; b++) cnt[b] = 8'd0;
        cnt[b1] = pick_count();
        cnt[b2] = pick_count();
        if (cnt[b1] == 0 && cnt[b2] == 0) cnt[b1] = 8'($urandom_range(1, 255));
        return mk_word(cnt[0], cnt[1], cnt[2], cnt[3], pick_draw());
    endfunction

    function automatic base_word_t noise_word(input int b1, input int b2);
        base_word_t w;
        int         third;
        case ($urandom_range(0, 2))
            0: w = mk_word(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                           pick_draw());
            1: w = mk_word(8'd0, 8'd0, 8'd0, 8'd0, pick_draw());
            default: begin
                w = two_base_word(b1, b2);
                third = b1;
                while (third == b1 || third == b2) third = $urandom_range(0, 3);
                case (third)
                    BASE_A: w.count_a = 8'($urandom_range(1, 255));
                    BASE_C: w.count_c = 8'($urandom_range(1, 255));
                    BASE_G: w.count_g = 8'($urandom_range(1, 255));
                    default: w.count_t = 8'($urandom_range(1, 255));
                endcase
            end
        endcase
        return w;
    endfunction

    // clean sites stay diallelic; the others get broken words mixed in
    task automatic queue_site(input int count, input bit clean);
        int b1;
        int b2;
        b1 = $urandom_range(0, 3);
        b2 = (b1 + $urandom_range(1, 3)) % 4;
        for (int i = 0; i < count; i++) begin
            if (!clean && $urandom_range(0, 99) < 30)
                words_to_send.push_back(noise_word(b1, b2));
            else
                words_to_send.push_back(two_base_word(b1, b2));
        end
    endtask

    function automatic bit pick_clean();
        return $urandom_range(0, 3) != 0;
    endfunction

    task automatic write_site_size(input logic [CFG_W-1:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        site_size_reg = v;
    endtask

    task automatic start_phase(input logic [CFG_W-1:0] v);
        write_site_size(v);
        src_gaps_on  = $urandom_range(0, 3) != 0;
        sink_gaps_on = $urandom_range(0, 3) != 0;
    endtask

    task automatic settle_block();
        int waited;
        while (words_to_send.size() != 0 || s_tvalid) @(posedge aclk);
        waited = 0;
        while (genotypes_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (genotypes_due.size() != 0) begin
            report_mismatch($sformatf("%0d genotype words never arrived",
                                      genotypes_due.size()));
            genotypes_due.delete();
        end
        // rejected sites give nothing, so let the evaluation finish
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic check_genotype();
        genotype_t          want;
        logic [INDEX_W-1:0] got_index;
        logic               got_first;
        got_index = m_tdata[INDEX_W-1:0];
        got_first = m_tdata[INDEX_W];
        if (genotypes_due.size() == 0) begin
            report_mismatch($sformatf("unexpected word, index %0d", got_index));
            return;
        end
        want = genotypes_due.pop_front();
        if (got_index !== want.individual_index)
            report_mismatch($sformatf("index %0d, want %0d", got_index,
                                      want.individual_index));
        if (got_first !== want.is_first_allele)
            report_mismatch($sformatf("is_first_allele %b at index %0d, want %b",
                                      got_first, want.individual_index,
                                      want.is_first_allele));
        if (m_tlast !== want.last)
            report_mismatch($sformatf("tlast %b at index %0d, want %b", m_tlast,
                                      want.individual_index, want.last));
    endtask

    // the driver puts a gap of random length after each word when source gaps are on
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) load_individual(word_on_bus);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (words_to_send.size() != 0) begin
                    word_on_bus = words_to_send.pop_front();
                    s_tdata  <= word_on_bus;
                    s_tvalid <= 1'b1;
                    if (src_gaps_on) gap_left = idle_len();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) check_genotype();
            if (hold_on) begin
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (sink_gaps_on) stall_left = idle_len();
            end
        end
    end

    // long receiver hold so both banks fill and s_tready drops
    initial begin
        wait (hold_go);
        @(posedge aclk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_on <= 1'b0;
    end

    initial begin
        logic [CFG_W-1:0] mid_size;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed sites at the reset size of two
        words_to_send.push_back(mk_word(8'd255, 8'd0, 8'd0, 8'd0, 16'd0));
        words_to_send.push_back(mk_word(8'd0, 8'd0, 8'd0, 8'd255, 16'hFFFF));
        // draw exactly on the C/T boundary
        words_to_send.push_back(mk_word(8'd0, 8'd1, 8'd0, 8'd1, 16'd32767));
        words_to_send.push_back(mk_word(8'd0, 8'd1, 8'd0, 8'd1, 16'd32768));
        // zero depth
        words_to_send.push_back(mk_word(8'd0, 8'd0, 8'd0, 8'd0, 16'hFFFF));
        words_to_send.push_back(mk_word(8'd0, 8'd0, 8'd9, 8'd3, 16'd100));
        // three bases seen, two drawn
        words_to_send.push_back(mk_word(8'd5, 8'd5, 8'd0, 8'd0, 16'd0));
        words_to_send.push_back(mk_word(8'd0, 8'd0, 8'd7, 8'd0, 16'd40000));
        // two bases seen, one drawn
        words_to_send.push_back(mk_word(8'd100, 8'd1, 8'd0, 8'd0, 16'd0));
        words_to_send.push_back(mk_word(8'd100, 8'd1, 8'd0, 8'd0, 16'd0));
        // all four bases full
        words_to_send.push_back(mk_word(8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF));
        words_to_send.push_back(mk_word(8'd255, 8'd255, 8'd255, 8'd255, 16'd0));
        // G/T boundary, G first
        words_to_send.push_back(mk_word(8'd0, 8'd0, 8'd128, 8'd128, 16'd32767));
        words_to_send.push_back(mk_word(8'd0, 8'd0, 8'd128, 8'd128, 16'd32768));
        // lowest allele on the second individual
        words_to_send.push_back(mk_word(8'd0, 8'd0, 8'd0, 8'd255, 16'hFFFF));
        words_to_send.push_back(mk_word(8'd0, 8'd0, 8'd255, 8'd0, 16'd12345));
        settle_block();

        start_phase(7'd0);
        repeat (10) queue_site(2, pick_clean());
        settle_block();

        start_phase(7'd127);
        queue_site(MAX_INDIVIDUALS_DEF, 1'b1);
        settle_block();

        hold_go = 1'b1;
        start_phase(7'd3);
        repeat (12) queue_site(3, pick_clean());
        settle_block();

        // leave a site three words in, then shrink the size under it
        start_phase(7'd5);
        repeat (2) queue_site(5, 1'b1);
        queue_site(3, 1'b1);
        settle_block();

        start_phase(7'd1);
        queue_site(1, 1'b1);
        repeat (8) queue_site(2, pick_clean());
        settle_block();

        start_phase(7'd64);
        queue_site(MAX_INDIVIDUALS_DEF, 1'b1);
        settle_block();

        mid_size = CFG_W'($urandom_range(4, 12));
        start_phase(mid_size);
        repeat (3) queue_site(site_size(mid_size), pick_clean());
        settle_block();

        start_phase(7'd2);
        repeat (4) queue_site(2, pick_clean());
        settle_block();

        if (mismatch_count == 0) begin
            $display("diallelic_site_allele_sampler_tb: PASS");
        end else begin
            $display("diallelic_site_allele_sampler_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("diallelic_site_allele_sampler_tb: FAIL");
        $finish;
    end

endmodule
